[sv/hops_pkg.sv]
// Shared constants for the Hilbert-order point sorter.
package hops_pkg;
	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_MAX_POINTS = 1024;
	localparam int XY_W           = 16;
	localparam int TAG_W          = 10;
	localparam int OUT_KEY_W      = 32;
endpackage

[sv/hops_keygen.sv]
// Iterative Skilling axes-to-transpose Hilbert key generator, one curve level per cycle.
module hops_keygen #(
	parameter int COORD_BITS = hops_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hops_pkg::XY_W-1:0]         raw_x,
	input  logic [hops_pkg::XY_W-1:0]         raw_y,
	output logic                              done,
	output logic [2*COORD_BITS-1:0]           key
);
	import hops_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int POS_W = $clog2(CB);

	logic [CB-1:0]    w0_q, w1_q;
	logic [POS_W-1:0] pos_q;
	logic             busy_q, fin_q, done_q;
	logic [2*CB-1:0]  key_q;
	logic [CB-1:0]    gx, gy, p, n0, n1, t1, f1, tf, f0, f1b;
	logic [2*CB-1:0]  key_d;

	// Offset by half range to an unsigned grid coordinate.
	always_comb begin
		logic [XY_W-1:0] ux, uy;
		logic [CB+XY_W-1:0] ex, ey;
		ux = raw_x ^ {1'b1, {(XY_W-1){1'b0}}};
		uy = raw_y ^ {1'b1, {(XY_W-1){1'b0}}};
		ex = {ux, {CB{1'b0}}};
		ey = {uy, {CB{1'b0}}};
		gx = ex[CB+XY_W-1 -: CB];
		gy = ey[CB+XY_W-1 -: CB];
	end

	// One level of the transform.
	always_comb begin
		p  = (CB'(1) << pos_q) - CB'(1);
		n0 = w0_q;
		n1 = w1_q;
		t1 = '0;
		if (n0[pos_q]) begin
			n0 = n0 ^ p;
		end
		if (n1[pos_q]) begin
			n0 = n0 ^ p;
		end else begin
			t1 = (n0 ^ n1) & p;
			n0 = n0 ^ t1;
			n1 = n1 ^ t1;
		end
	end

	// Gray encode and interleave, x word above y word at each level.
	always_comb begin
		f1 = w1_q ^ w0_q;
		for (int j = 0; j < CB; j++) begin
			tf[j] = ^(f1 >> (j + 1));
		end
		f0  = w0_q ^ tf;
		f1b = f1 ^ tf;
		for (int j = 0; j < CB; j++) begin
			key_d[2*j+1] = f0[j];
			key_d[2*j]   = f1b[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
			end else if (busy_q && !fin_q) begin
				if (pos_q == POS_W'(1)) begin
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w0_q  <= gx;
			w1_q  <= gy;
			pos_q <= POS_W'(CB - 1);
		end else if (busy_q && !fin_q) begin
			w0_q  <= n0;
			w1_q  <= n1;
			pos_q <= pos_q - POS_W'(1);
		end
		if (fin_q) begin
			key_q <= key_d;
		end
	end

	assign done = done_q;
	assign key  = key_q;
endmodule

[sv/hops_sorter.sv]
// Stable bottom-up merge sort of key and index records over two ping-pong memories.
module hops_sorter #(
	parameter int COORD_BITS = hops_pkg::DEF_COORD_BITS,
	parameter int MAX_POINTS = hops_pkg::DEF_MAX_POINTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [$clog2(MAX_POINTS)-1:0]      wr_addr,
	input  logic [2*COORD_BITS-1:0]            wr_key,
	input  logic                               start,
	input  logic [$clog2(MAX_POINTS+1)-1:0]    num,
	output logic                               done,
	input  logic [$clog2(MAX_POINTS)-1:0]      rd_addr,
	output logic [2*COORD_BITS-1:0]            rd_key,
	output logic [$clog2(MAX_POINTS)-1:0]      rd_idx
);
	import hops_pkg::*;

	localparam int KW    = 2 * COORD_BITS;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int NW    = $clog2(MAX_POINTS + 1);
	localparam int CW    = IW + 3;
	localparam int REC_W = KW + IW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_CMP  = 2'd3;

	logic [REC_W-1:0] mem0 [MAX_POINTS];
	logic [REC_W-1:0] mem1 [MAX_POINTS];
	logic [REC_W-1:0] r0a_q, r0b_q, r1a_q, r1b_q, ra, rb, wdat;
	logic [1:0]       state_q;
	logic             src_q, done_q, take_b, a_ok, b_ok, we0, we1;
	logic [CW-1:0]    n_q, wid_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic [CW-1:0]    lo_w, lo_2w;
	logic [IW-1:0]    addr_a, addr_b, waddr;

	assign addr_a = (state_q == S_IDLE) ? rd_addr : a_q[IW-1:0];
	assign addr_b = b_q[IW-1:0];
	assign ra     = src_q ? r1a_q : r0a_q;
	assign rb     = src_q ? r1b_q : r0b_q;
	assign a_ok   = a_q < mid_q;
	assign b_ok   = b_q < hi_q;
	// A tie goes to the left run, which keeps load order.
	assign take_b = b_ok && (!a_ok || (rb[REC_W-1 -: KW] < ra[REC_W-1 -: KW]));
	assign wdat   = (state_q == S_IDLE) ? {wr_key, wr_addr} : (take_b ? rb : ra);
	assign waddr  = (state_q == S_IDLE) ? wr_addr : k_q[IW-1:0];
	assign we0    = (state_q == S_IDLE && wr_en) || (state_q == S_CMP && src_q);
	assign we1    = state_q == S_CMP && !src_q;
	assign lo_w   = lo_q + wid_q;
	assign lo_2w  = lo_q + (wid_q << 1);

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[waddr] <= wdat;
		end
		if (we1) begin
			mem1[waddr] <= wdat;
		end
		r0a_q <= mem0[addr_a];
		r0b_q <= mem0[addr_b];
		r1a_q <= mem1[addr_a];
		r1b_q <= mem1[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						src_q <= 1'b0;
						if (num <= NW'(1)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: state_q <= S_RD;
				S_RD:  state_q <= S_CMP;
				S_CMP: begin
					if (k_q + CW'(1) == hi_q) begin
						if (hi_q == n_q) begin
							src_q <= ~src_q;
							if ((wid_q << 1) >= n_q) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RUN;
							end
						end else begin
							state_q <= S_RUN;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= CW'(num);
				wid_q <= CW'(1);
				lo_q  <= '0;
			end
			S_RUN: begin
				mid_q <= (lo_w < n_q) ? lo_w : n_q;
				hi_q  <= (lo_2w < n_q) ? lo_2w : n_q;
				a_q   <= lo_q;
				b_q   <= (lo_w < n_q) ? lo_w : n_q;
				k_q   <= lo_q;
			end
			S_CMP: begin
				k_q <= k_q + CW'(1);
				if (take_b) begin
					b_q <= b_q + CW'(1);
				end else begin
					a_q <= a_q + CW'(1);
				end
				if (k_q + CW'(1) == hi_q) begin
					if (hi_q == n_q) begin
						wid_q <= wid_q << 1;
						lo_q  <= '0;
					end else begin
						lo_q <= hi_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign rd_key = ra[REC_W-1 -: KW];
	assign rd_idx = ra[IW-1:0];
endmodule

[sv/hilbert_order_point_sorter_top.sv]
// Top level of the Hilbert-order point sorter: load, key, sort and emit control.
// Loading keys each point transfer in the one-level-per-cycle key unit before the next is taken.
// Sorting sets up each merged run, then reads and compares each point, in each of ceil(log2 N) passes.
// Emitting steps through a sorted-order read, a point read, then the output register for each point.
// Reset clears the phase, the point count and the output valid; the memories keep their contents
// and need no clearing pass, since only entries written in the current load are read.
module hilbert_order_point_sorter_top #(
	parameter int COORD_BITS = hops_pkg::DEF_COORD_BITS,
	parameter int MAX_POINTS = hops_pkg::DEF_MAX_POINTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [hops_pkg::XY_W-1:0]      point_x,
	input  logic signed [hops_pkg::XY_W-1:0]      point_y,
	input  logic [hops_pkg::TAG_W-1:0]            point_tag,
	input  logic                                  last_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hops_pkg::TAG_W-1:0]            sorted_tag,
	output logic signed [hops_pkg::XY_W-1:0]      sorted_x,
	output logic signed [hops_pkg::XY_W-1:0]      sorted_y,
	output logic [hops_pkg::OUT_KEY_W-1:0]        curve_key,
	output logic                                  last_out
);
	import hops_pkg::*;

	localparam int KW = 2 * COORD_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int PW = 2 * XY_W + TAG_W;

	// Phases of the block.
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_KEY  = 3'd1;
	localparam logic [2:0] ST_SORT = 3'd2;
	localparam logic [2:0] ST_F1   = 3'd3;
	localparam logic [2:0] ST_F2   = 3'd4;
	localparam logic [2:0] ST_RDY  = 3'd5;

	logic [2:0]          state_q;
	logic [NW-1:0]       count_q, epos_q;
	logic [XY_W-1:0]     x_q, y_q;
	logic [TAG_W-1:0]    tag_q;
	logic                last_q;
	logic                in_xfer, out_free, full, final_pt;
	logic                kg_start, kg_done, sort_start, sort_done;
	logic [KW-1:0]       kg_key, rd_key, key_q;
	logic [IW-1:0]       rd_idx;
	logic [PW-1:0]       pmem [MAX_POINTS];
	logic [PW-1:0]       prd_q;
	logic                ov_q, olast_q;
	logic [TAG_W-1:0]    otag_q;
	logic [XY_W-1:0]     ox_q, oy_q;
	logic [KW+OUT_KEY_W-1:0] okey_q;

	assign full     = count_q == NW'(MAX_POINTS);
	assign out_free = !ov_q || out_ready;
	// An item is taken while loading, or in the emit phase once the next point is prefetched.
	assign in_ready = (state_q == ST_LOAD) || (state_q == ST_RDY && out_free);
	assign in_xfer  = in_valid && in_ready;
	assign final_pt = epos_q + NW'(1) >= count_q;
	assign kg_start = in_xfer && state_q == ST_LOAD && !full;
	// A dropped point's last mark still ends loading.
	assign sort_start = (in_xfer && state_q == ST_LOAD && full && last_in)
		|| (state_q == ST_KEY && kg_done && last_q);

	hops_keygen #(
		.COORD_BITS(COORD_BITS)
	) u_keygen (
		.clk   (clk),
		.arst_n(arst_n),
		.start (kg_start),
		.raw_x (point_x),
		.raw_y (point_y),
		.done  (kg_done),
		.key   (kg_key)
	);

	hops_sorter #(
		.COORD_BITS(COORD_BITS),
		.MAX_POINTS(MAX_POINTS)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (state_q == ST_KEY && kg_done),
		.wr_addr(count_q[IW-1:0]),
		.wr_key (kg_key),
		.start  (sort_start),
		.num    ((state_q == ST_KEY) ? count_q + NW'(1) : count_q),
		.done   (sort_done),
		.rd_addr(epos_q[IW-1:0]),
		.rd_key (rd_key),
		.rd_idx (rd_idx)
	);

	// Point memory in load order; read once per emitted point.
	always_ff @(posedge clk) begin
		if (state_q == ST_KEY && kg_done) begin
			pmem[count_q[IW-1:0]] <= {tag_q, x_q, y_q};
		end
		if (state_q == ST_F2) begin
			prd_q <= pmem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			epos_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			// The output register empties on its transfer unless a new point refills it.
			if (out_ready && !(in_xfer && state_q == ST_RDY)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (kg_start) begin
						state_q <= ST_KEY;
					end else if (sort_start) begin
						state_q <= ST_SORT;
					end
				end
				ST_KEY: begin
					if (kg_done) begin
						count_q <= count_q + NW'(1);
						state_q <= last_q ? ST_SORT : ST_LOAD;
					end
				end
				ST_SORT: begin
					if (sort_done) begin
						epos_q  <= '0;
						state_q <= ST_F1;
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_RDY;
				ST_RDY: begin
					if (in_xfer) begin
						ov_q <= 1'b1;
						if (final_pt) begin
							count_q <= '0;
							epos_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							epos_q  <= epos_q + NW'(1);
							state_q <= ST_F1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && state_q == ST_LOAD) begin
			x_q    <= point_x;
			y_q    <= point_y;
			tag_q  <= point_tag;
			last_q <= last_in;
		end
		if (state_q == ST_F2) begin
			key_q <= rd_key;
		end
		if (in_xfer && state_q == ST_RDY) begin
			otag_q  <= prd_q[PW-1 -: TAG_W];
			ox_q    <= prd_q[2*XY_W-1 -: XY_W];
			oy_q    <= prd_q[XY_W-1:0];
			okey_q  <= {{OUT_KEY_W{1'b0}}, key_q};
			olast_q <= final_pt;
		end
	end

	assign out_valid  = ov_q;
	assign sorted_tag = otag_q;
	assign sorted_x   = ox_q;
	assign sorted_y   = oy_q;
	assign curve_key  = okey_q[OUT_KEY_W-1:0];
	assign last_out   = olast_q;

	// Input transfers happen only while loading or with a prefetched point on hand.
	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_LOAD || state_q == ST_RDY))
		else $error("input ready outside load or emit-ready phase");

	// The point count never passes the store depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_POINTS))
		else $error("point count exceeds store depth");

	// The sorter finishes only while the block waits for it.
	a_sort_done: assert property (@(posedge clk) disable iff (!arst_n)
		sort_done |-> state_q == ST_SORT)
		else $error("sort done outside sort phase");

	// An emitted point leaves the emit-ready phase at once.
	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && state_q == ST_RDY) |=> (out_valid && (state_q == ST_F1 || state_q == ST_LOAD)))
		else $error("emit transfer did not produce a result");
endmodule
